/* src/four_class_priority_call_server_top_macros.svh */
// Assertion macros used by the datapath RTL of the call server.
`ifndef FOUR_CLASS_PRIORITY_CALL_SERVER_TOP_MACROS_SVH
`define FOUR_CLASS_PRIORITY_CALL_SERVER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCPCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("call server check failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define FCPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("call server check failed (next cycle)");

`endif

/* src/fcpcs_pkg.sv */
package fcpcs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(NUM_CLASSES * QUEUE_DEPTH);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [CLS_W-1:0] CLASS_TOP = CLS_W'(NUM_CLASSES - 1);
    localparam logic [15:0]      TICK_MAX  = 16'hFFFF;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  member_class;
        logic [7:0]  caller_id;
        logic [15:0] arrival_tick;
        logic [15:0] call_length;
    } t_in_item;

    typedef struct packed {
        logic       answered_valid;
        logic [7:0] answered_id;
        logic       finished_valid;
        logic [7:0] finished_id;
        logic       all_empty;
        logic       dropped;
    } t_out_item;

    // One stored request.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] length;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SRV_RD,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_TICK_END
    } t_state;

    typedef struct packed {
        logic             load_item;
        logic             enqueue;
        logic             rd_en;
        logic [CLS_W-1:0] rd_class;
        logic             take_head;
        logic             tick_end;
    } t_dp_cmd;

    typedef struct packed {
        logic                   srv_busy;
        logic [CLS_W-1:0]       srv_class;
        logic [NUM_CLASSES-1:0] count_nz;
        logic                   eligible;
    } t_dp_status;

endpackage

/* src/four_class_priority_call_server_top.sv */
// Channel      Handshake            Payload                   Direction
// -----------  -------------------  ------------------------  ---------
// item in      start, busy          i_item (t_in_item)        input
// result out   o_done (strobe)      o_result (t_out_item)     output
//
// An item is taken at an edge where start is high and busy is low. An arrival
// passes through S_ENQ; a tick passes through S_SRV_RD and S_TICK_END when the server is
// already busy, else scans the queue heads one at a time (S_SCAN_RD, and S_SCAN_CHK
// for a non-empty head) before S_TICK_END. Every item gives one result, shown for one
// cycle with o_done high in the cycle after the item completes; the receiver cannot stall it.
// Reset is synchronous and active low; the request store itself is not cleared.

module four_class_priority_call_server_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  fcpcs_pkg::t_in_item  i_item,
    output logic                 busy,
    output logic                 o_done,
    output fcpcs_pkg::t_out_item o_result
);

    // Command and status traffic between the sequencer and the datapath.
    fcpcs_pkg::t_dp_cmd    cmd;
    fcpcs_pkg::t_dp_status status;

    // The controller walks each transaction through its steps: one write for
    // an arrival, or for a tick a read of the serving head when the server is busy,
    // else a scan of the queue heads from platinum downwards, then the service update.
    fcpcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds the request store, the queue pointers, the server
    // state and the tick counter, and registers the result of each transaction.
    fcpcs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

/* src/fcpcs_ctrl.sv */
module fcpcs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_opcode,
    input  fcpcs_pkg::t_dp_status i_status,
    output fcpcs_pkg::t_dp_cmd    o_cmd,
    output logic                  o_busy
);

    fcpcs_pkg::t_state                 r_state;
    fcpcs_pkg::t_state                 n_state;
    logic [fcpcs_pkg::CLS_W-1:0]       r_cls;
    logic [fcpcs_pkg::CLS_W-1:0]       n_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcpcs_pkg::S_IDLE;
            r_cls   <= '0;
        end else begin
            r_state <= n_state;
            r_cls   <= n_cls;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cls   = r_cls;
        o_cmd   = '0;
        case (r_state)
            fcpcs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_item = 1'b1;
                    if (i_opcode == fcpcs_pkg::OP_TICK) begin
                        if (i_status.srv_busy) begin
                            n_state = fcpcs_pkg::S_SRV_RD;
                        end else begin
                            n_cls   = fcpcs_pkg::CLASS_TOP;
                            n_state = fcpcs_pkg::S_SCAN_RD;
                        end
                    end else begin
                        n_state = fcpcs_pkg::S_ENQ;
                    end
                end
            end
            fcpcs_pkg::S_ENQ: begin
                o_cmd.enqueue = 1'b1;
                n_state       = fcpcs_pkg::S_IDLE;
            end
            fcpcs_pkg::S_SRV_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_class = i_status.srv_class;
                n_state        = fcpcs_pkg::S_TICK_END;
            end
            fcpcs_pkg::S_SCAN_RD: begin
                o_cmd.rd_class = r_cls;
                if (i_status.count_nz[r_cls]) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = fcpcs_pkg::S_SCAN_CHK;
                end else if (r_cls == '0) begin
                    n_state = fcpcs_pkg::S_TICK_END;
                end else begin
                    n_cls = r_cls - 1'b1;
                end
            end
            fcpcs_pkg::S_SCAN_CHK: begin
                o_cmd.rd_class = r_cls;
                if (i_status.eligible) begin
                    o_cmd.take_head = 1'b1;
                    n_state         = fcpcs_pkg::S_TICK_END;
                end else if (r_cls == '0) begin
                    n_state = fcpcs_pkg::S_TICK_END;
                end else begin
                    n_cls   = r_cls - 1'b1;
                    n_state = fcpcs_pkg::S_SCAN_RD;
                end
            end
            fcpcs_pkg::S_TICK_END: begin
                o_cmd.tick_end = 1'b1;
                n_state        = fcpcs_pkg::S_IDLE;
            end
            default: begin
                n_state = fcpcs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != fcpcs_pkg::S_IDLE);

endmodule

/* src/fcpcs_datapath.sv */
`include "four_class_priority_call_server_top_macros.svh"

module fcpcs_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcpcs_pkg::t_in_item   i_item,
    input  fcpcs_pkg::t_dp_cmd    i_cmd,
    output fcpcs_pkg::t_dp_status o_status,
    output logic                  o_done,
    output fcpcs_pkg::t_out_item  o_result
);

    localparam int SUM_W = fcpcs_pkg::IDX_W + 2;

    fcpcs_pkg::t_entry   r_mem [fcpcs_pkg::NUM_CLASSES * fcpcs_pkg::QUEUE_DEPTH];
    fcpcs_pkg::t_entry   r_rd_data;
    fcpcs_pkg::t_in_item r_item;

    logic [fcpcs_pkg::IDX_W-1:0] r_head  [fcpcs_pkg::NUM_CLASSES];
    logic [fcpcs_pkg::IDX_W-1:0] n_head  [fcpcs_pkg::NUM_CLASSES];
    logic [fcpcs_pkg::CNT_W-1:0] r_count [fcpcs_pkg::NUM_CLASSES];
    logic [fcpcs_pkg::CNT_W-1:0] n_count [fcpcs_pkg::NUM_CLASSES];

    logic                        r_srv_busy,  n_srv_busy;
    logic [fcpcs_pkg::CLS_W-1:0] r_srv_class, n_srv_class;
    logic [15:0]                 r_elapsed,   n_elapsed;
    logic [15:0]                 r_tick,      n_tick;
    logic                        r_ans_v,     n_ans_v;
    logic [7:0]                  r_ans_id,    n_ans_id;
    logic                        r_out_valid, n_out_valid;
    fcpcs_pkg::t_out_item        r_out,       n_out;

    logic                         wr_en;
    logic [fcpcs_pkg::ADDR_W-1:0] wr_addr;
    logic [fcpcs_pkg::ADDR_W-1:0] rd_addr;
    fcpcs_pkg::t_entry            wr_data;
    logic [fcpcs_pkg::CLS_W-1:0]  enq_cls;
    logic                         enq_full;
    logic [SUM_W-1:0]             slot_sum;
    logic [fcpcs_pkg::IDX_W-1:0]  slot;
    logic                         any_queued;

    function automatic logic [fcpcs_pkg::ADDR_W-1:0] mem_addr(
        input logic [fcpcs_pkg::CLS_W-1:0] cls,
        input logic [fcpcs_pkg::IDX_W-1:0] idx
    );
        return fcpcs_pkg::ADDR_W'(fcpcs_pkg::ADDR_W'(cls)
                                  * fcpcs_pkg::ADDR_W'(fcpcs_pkg::QUEUE_DEPTH)
                                  + fcpcs_pkg::ADDR_W'(idx));
    endfunction

    // Request store: one write port for arrivals, one registered read port for heads.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < fcpcs_pkg::NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_srv_busy  <= 1'b0;
            r_srv_class <= '0;
            r_elapsed   <= '0;
            r_tick      <= '0;
            r_ans_v     <= 1'b0;
            r_ans_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            for (int c = 0; c < fcpcs_pkg::NUM_CLASSES; c++) begin
                r_head[c]  <= n_head[c];
                r_count[c] <= n_count[c];
            end
            r_srv_busy  <= n_srv_busy;
            r_srv_class <= n_srv_class;
            r_elapsed   <= n_elapsed;
            r_tick      <= n_tick;
            r_ans_v     <= n_ans_v;
            r_ans_id    <= n_ans_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        for (int c = 0; c < fcpcs_pkg::NUM_CLASSES; c++) begin
            n_head[c]  = r_head[c];
            n_count[c] = r_count[c];
        end
        n_srv_busy  = r_srv_busy;
        n_srv_class = r_srv_class;
        n_elapsed   = r_elapsed;
        n_tick      = r_tick;
        n_ans_v     = r_ans_v;
        n_ans_id    = r_ans_id;
        n_out_valid = 1'b0;
        n_out       = r_out;
        any_queued  = 1'b0;

        rd_addr  = mem_addr(i_cmd.rd_class, r_head[i_cmd.rd_class]);
        enq_cls  = r_item.member_class;
        enq_full = (r_count[enq_cls] == fcpcs_pkg::CNT_W'(fcpcs_pkg::QUEUE_DEPTH));
        slot_sum = SUM_W'(r_head[enq_cls]) + SUM_W'(r_count[enq_cls]);
        if (slot_sum >= SUM_W'(fcpcs_pkg::QUEUE_DEPTH)) begin
            slot = fcpcs_pkg::IDX_W'(slot_sum - SUM_W'(fcpcs_pkg::QUEUE_DEPTH));
        end else begin
            slot = fcpcs_pkg::IDX_W'(slot_sum);
        end
        wr_en           = 1'b0;
        wr_addr         = mem_addr(enq_cls, slot);
        wr_data.id      = r_item.caller_id;
        wr_data.arrival = r_item.arrival_tick;
        wr_data.length  = r_item.call_length;

        if (i_cmd.load_item) begin
            n_ans_v  = 1'b0;
            n_ans_id = '0;
        end

        if (i_cmd.enqueue) begin
            if (!enq_full) begin
                wr_en             = 1'b1;
                n_count[enq_cls]  = r_count[enq_cls] + 1'b1;
            end
            n_out_valid          = 1'b1;
            n_out.answered_valid = 1'b0;
            n_out.answered_id    = '0;
            n_out.finished_valid = 1'b0;
            n_out.finished_id    = '0;
            n_out.dropped        = enq_full;
        end

        if (i_cmd.take_head) begin
            n_srv_busy  = 1'b1;
            n_srv_class = i_cmd.rd_class;
            n_elapsed   = '0;
            n_ans_v     = 1'b1;
            n_ans_id    = r_rd_data.id;
        end

        if (i_cmd.tick_end) begin
            n_out_valid          = 1'b1;
            n_out.answered_valid = r_ans_v;
            n_out.answered_id    = r_ans_id;
            n_out.finished_valid = 1'b0;
            n_out.finished_id    = '0;
            n_out.dropped        = 1'b0;
            if (r_srv_busy) begin
                if (r_count[r_srv_class] == '0) begin
                    n_srv_busy = 1'b0;
                end else if ({1'b0, r_elapsed} + 17'd1 >= {1'b0, r_rd_data.length}) begin
                    n_out.finished_valid = 1'b1;
                    n_out.finished_id    = r_rd_data.id;
                    if (r_head[r_srv_class]
                        == fcpcs_pkg::IDX_W'(fcpcs_pkg::QUEUE_DEPTH - 1)) begin
                        n_head[r_srv_class] = '0;
                    end else begin
                        n_head[r_srv_class] = r_head[r_srv_class] + 1'b1;
                    end
                    n_count[r_srv_class] = r_count[r_srv_class] - 1'b1;
                    n_srv_busy           = 1'b0;
                    n_elapsed            = '0;
                end else if (r_elapsed != fcpcs_pkg::TICK_MAX) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end
            if (r_tick != fcpcs_pkg::TICK_MAX) begin
                n_tick = r_tick + 16'd1;
            end
        end

        for (int c = 0; c < fcpcs_pkg::NUM_CLASSES; c++) begin
            any_queued = any_queued | (n_count[c] != '0);
        end
        if (n_out_valid) begin
            n_out.all_empty = !any_queued;
        end
    end

    always_comb begin
        o_status.srv_busy  = r_srv_busy;
        o_status.srv_class = r_srv_class;
        for (int c = 0; c < fcpcs_pkg::NUM_CLASSES; c++) begin
            o_status.count_nz[c] = (r_count[c] != '0);
        end
        o_status.eligible = (r_rd_data.arrival <= r_tick);
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

    `FCPCS_ASSERT_NEXT(a_done_single_cycle, i_clk, i_rst_n, r_out_valid, !r_out_valid)
    `FCPCS_ASSERT_NEXT(a_take_starts_service, i_clk, i_rst_n, i_cmd.take_head, r_srv_busy && r_ans_v)
    `FCPCS_ASSERT_IMPL(a_finish_frees_server, i_clk, i_rst_n, r_out_valid && r_out.finished_valid, !r_srv_busy && (r_elapsed == '0))

endmodule
